// ===== rtl/sglf_pkg.sv =====
// Shared package for the scheduled linear-fade gate.
// Holds command and register codes, fixed field widths and the lane control word.
// No dependencies.
package sglf_pkg;

    localparam int POS_W       = 47;  // frame position width
    localparam int OPEN_W      = 48;  // signed open time width
    localparam int CMD_W       = 2;
    localparam int FAST_FACTOR = 5;
    localparam int RAMP_RESET  = 66;
    localparam int TAKE_RESET  = 2;
    localparam int TAKE_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_SHUT  = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_RAMP_STEP  = 1'b0,
        REG_TAKE_WIDTH = 1'b1
    } t_reg_idx;

    // per-frame control handed from the gain stage to the lanes and merge
    typedef struct packed {
        logic left_en;
        logic right_en;
        logic passing;
    } t_lane_ctrl;

endpackage

// ===== rtl/sglf_ctrl.sv =====
// Gate state and gain ramp: command decode, position tracking, one gain step per frame.
// Also holds the configuration registers. Depends on sglf_pkg.
module sglf_ctrl #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  sglf_pkg::t_reg_idx            i_cfg_idx,
    input  logic [GAIN_FRAC_BITS:0]       i_cfg_data,
    input  logic                          i_accept,
    input  sglf_pkg::t_cmd                i_command,
    input  logic [sglf_pkg::POS_W-1:0]    i_position,
    input  logic [sglf_pkg::OPEN_W-1:0]   i_open_time,
    input  logic                          i_fast_shut,
    input  logic                          i_left_present,
    input  logic                          i_right_present,
    output logic                          o_frame,
    output logic [GAIN_FRAC_BITS:0]       o_gain,
    output sglf_pkg::t_lane_ctrl          o_ctrl
);

    localparam int GB     = GAIN_FRAC_BITS + 1;
    localparam int STEP_W = GB + 3;
    localparam int SUM_W  = STEP_W + 1;
    localparam logic [GB-1:0]    GAIN_ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [SUM_W-1:0] ONE_WIDE  = {{(SUM_W-GB){1'b0}}, GAIN_ONE};

    logic [GB-1:0]                  r_ramp_step;
    logic [sglf_pkg::TAKE_W-1:0]    r_take_width;
    logic [GB-1:0]                  r_gain, n_gain;
    logic                           r_open_wanted;
    logic [sglf_pkg::OPEN_W-1:0]    r_open_pos;
    logic                           r_shut_fast;
    logic [sglf_pkg::POS_W-1:0]     r_expected;
    logic                           r_pos_known;

    logic                           is_frame;
    logic [GB-1:0]                  gain_base;
    logic [STEP_W-1:0]              step;
    logic [SUM_W-1:0]               sum;
    logic                           going_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step  <= GB'(sglf_pkg::RAMP_RESET);
            r_take_width <= sglf_pkg::TAKE_W'(sglf_pkg::TAKE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sglf_pkg::REG_RAMP_STEP:  r_ramp_step  <= i_cfg_data;
                sglf_pkg::REG_TAKE_WIDTH: r_take_width <= i_cfg_data[sglf_pkg::TAKE_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_frame  = i_accept && (i_command == sglf_pkg::CMD_FRAME);
    assign gain_base = (r_pos_known && (i_position != r_expected)) ? '0 : r_gain;

    // fast shut: step times five, as x4 + x1
    always_comb begin
        if (!r_open_wanted && r_shut_fast)
            step = {1'b0, r_ramp_step, 2'b00} + {3'b000, r_ramp_step};
        else
            step = {3'b000, r_ramp_step};
    end

    assign going_up = r_open_wanted &&
                      ($signed({1'b0, i_position}) >= $signed(r_open_pos));
    assign sum      = {{(SUM_W-GB){1'b0}}, gain_base} + {1'b0, step};

    always_comb begin
        if (going_up)
            n_gain = (sum >= ONE_WIDE) ? GAIN_ONE : sum[GB-1:0];
        else if ({3'b000, gain_base} <= step)
            n_gain = '0;
        else
            n_gain = gain_base - step[GB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= '0;
            r_open_wanted <= 1'b0;
            r_open_pos    <= '0;
            r_shut_fast   <= 1'b0;
            r_expected    <= '0;
            r_pos_known   <= 1'b0;
        end else if (i_accept) begin
            unique case (i_command)
                sglf_pkg::CMD_OPEN: begin
                    r_open_pos    <= i_open_time;
                    r_shut_fast   <= 1'b0;
                    r_open_wanted <= 1'b1;
                end
                sglf_pkg::CMD_SHUT: begin
                    r_shut_fast   <= i_fast_shut;
                    r_open_wanted <= 1'b0;
                end
                sglf_pkg::CMD_FRAME: begin
                    r_gain      <= n_gain;
                    r_expected  <= i_position + 1'b1;
                    r_pos_known <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_frame          = is_frame;
    assign o_gain           = n_gain;
    assign o_ctrl.left_en   = i_left_present;
    assign o_ctrl.right_en  = i_right_present && r_take_width[1];
    assign o_ctrl.passing   = r_open_wanted || (n_gain != '0);

endmodule

// ===== rtl/sglf_lane.sv =====
// One channel lane: sample times gain, floor shift, zero when the source is absent.
// Result is registered. Depends on nothing.
module sglf_lane #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_enable,
    input  logic [GAIN_FRAC_BITS:0]       i_gain,
    output logic signed [SAMPLE_BITS-1:0] o_out
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_FRAC_BITS + 2;

    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      shifted;
    logic signed [SAMPLE_BITS-1:0] r_out;

    assign prod    = $signed(i_sample) * $signed({1'b0, i_gain});
    assign shifted = prod >>> GAIN_FRAC_BITS;  // arithmetic shift gives the floor

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= i_enable ? shifted[SAMPLE_BITS-1:0] : '0;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/scheduled_gate_linear_fade_unit.sv =====
// Scheduled linear-fade gate, top level: stream ports, gain stage, two lanes, merge.
// Pipeline: a sample frame passes the stage 1 register, then the lane and merge registers.
// Throughput: one word per cycle unless i_m_tready stalls the output; gain update is
// a loop through a single register, r_gain, in sglf_ctrl. Open and shut commands give no result.
// Reset (i_rst_n, synchronous, low) clears gate state, empties the pipe, sets
// ramp_step to 66 and take_width to 2.
module scheduled_gate_linear_fade_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [GAIN_FRAC_BITS:0]   i_cfg_data,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // position, left_sample, right_sample, left_present, right_present,
    // open_time, fast_shut, zero pad
    input  logic [((sglf_pkg::POS_W + 2 * SAMPLE_BITS + 2 + sglf_pkg::OPEN_W + 1 + 7)
                   / 8) * 8 - 1:0] i_s_tdata,
    // command
    input  logic [sglf_pkg::CMD_W-1:0] i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // left_out, right_out, gain_level, passing, zero pad
    output logic [((2 * SAMPLE_BITS + GAIN_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int GB       = GAIN_FRAC_BITS + 1;
    localparam int IN_BITS  = sglf_pkg::POS_W + 2 * SAMPLE_BITS + 2 + sglf_pkg::OPEN_W + 1;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * SAMPLE_BITS + GB + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int L_LO  = sglf_pkg::POS_W;
    localparam int R_LO  = L_LO + SAMPLE_BITS;
    localparam int LP_B  = R_LO + SAMPLE_BITS;
    localparam int RP_B  = LP_B + 1;
    localparam int OT_LO = RP_B + 1;
    localparam int FS_B  = OT_LO + sglf_pkg::OPEN_W;

    logic                          accept;
    logic                          frame;
    logic [GB-1:0]                 gain_next;
    sglf_pkg::t_lane_ctrl          ctrl_next;

    logic                          r_v1, r_v2;
    logic [GB-1:0]                 r_gain1, r_gain2;
    sglf_pkg::t_lane_ctrl          r_ctrl1;
    logic                          r_pass2;
    logic signed [SAMPLE_BITS-1:0] r_left1, r_right1;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;
    logic                          adv2;
    logic                          load2;

    assign adv2       = !r_v2 || i_m_tready;
    assign load2      = r_v1 && adv2;
    assign o_s_tready = !r_v1 || adv2;
    assign accept     = i_s_tvalid && o_s_tready;

    sglf_ctrl #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (sglf_pkg::t_reg_idx'(i_cfg_idx)),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_command       (sglf_pkg::t_cmd'(i_s_tuser)),
        .i_position      (i_s_tdata[sglf_pkg::POS_W-1:0]),
        .i_open_time     (i_s_tdata[FS_B-1:OT_LO]),
        .i_fast_shut     (i_s_tdata[FS_B]),
        .i_left_present  (i_s_tdata[LP_B]),
        .i_right_present (i_s_tdata[RP_B]),
        .o_frame         (frame),
        .o_gain          (gain_next),
        .o_ctrl          (ctrl_next)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (frame)
                r_v1 <= 1'b1;
            else if (adv2)
                r_v1 <= 1'b0;
            if (adv2)
                r_v2 <= r_v1;
        end
    end

    // stage 1 word: gain, lane control and samples
    always_ff @(posedge i_clk) begin
        if (frame) begin
            r_gain1  <= gain_next;
            r_ctrl1  <= ctrl_next;
            r_left1  <= i_s_tdata[R_LO-1:L_LO];
            r_right1 <= i_s_tdata[LP_B-1:R_LO];
        end
    end

    sglf_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_load   (load2),
        .i_sample (r_left1),
        .i_enable (r_ctrl1.left_en),
        .i_gain   (r_gain1),
        .o_out    (left_out)
    );

    sglf_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_load   (load2),
        .i_sample (r_right1),
        .i_enable (r_ctrl1.right_en),
        .i_gain   (r_gain1),
        .o_out    (right_out)
    );

    // merge: gain and status ride alongside the lane results
    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_gain2 <= r_gain1;
            r_pass2 <= r_ctrl1.passing;
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_pass2, r_gain2, right_out, left_out};

endmodule
